[design/eight_bit_cpu_alu_with_flags_defines.svh]
// Assertion macros used by the ALU top-level design file.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EBALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define EBALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ebalu_pkg.sv]
// Types and constants shared by the eight-bit ALU design files.
package ebalu_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned SelW     = 3;
  localparam int unsigned ActW     = 4;
  localparam int unsigned RegCount = 8;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD = 4'd0,
    ACT_ADD  = 4'd1,
    ACT_ADC  = 4'd2,
    ACT_SUB  = 4'd3,
    ACT_SBC  = 4'd4,
    ACT_AND  = 4'd5,
    ACT_XOR  = 4'd6,
    ACT_OR   = 4'd7,
    ACT_CP   = 4'd8,
    ACT_INC  = 4'd9,
    ACT_DEC  = 4'd10,
    ACT_CPL  = 4'd11,
    ACT_CCF  = 4'd12
  } action_e;

  typedef enum logic [SelW-1:0] {
    SEL_B   = 3'b000,
    SEL_C   = 3'b001,
    SEL_D   = 3'b010,
    SEL_E   = 3'b011,
    SEL_H   = 3'b100,
    SEL_L   = 3'b101,
    SEL_MEM = 3'b110,
    SEL_A   = 3'b111
  } reg_sel_e;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [SelW-1:0]  reg_sel;
    logic             use_immediate;
    logic [DataW-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] acc_out;
    logic [DataW-1:0] result_value;
    logic             mem_write;
    logic             zero_flag;
    logic             subtract_flag;
    logic             half_carry_flag;
    logic             carry_flag;
  } out_item_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

[design/ebalu_chan_if.sv]
// Valid/ready channel interface carrying one item per transfer.
interface ebalu_chan_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/ebalu_ram.sv]
// Generic RAM with one write port and two registered read ports.
module ebalu_ram #(
  parameter int unsigned Width = ebalu_pkg::DataW,
  parameter int unsigned Depth = ebalu_pkg::RegCount,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // A read in the same cycle as a write to that entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[design/eight_bit_cpu_alu_with_flags.sv]
// Top level of the eight-bit accumulator ALU with Z, N, H and C flags.
//
// Each transfer on in_i is one instruction: a register load, an accumulator
// operation (ADD, ADC, SUB, SBC, AND, XOR, OR, CP), INC or DEC of a register
// or of the memory byte at HL, or CPL or CCF. Each instruction gives exactly
// one transfer on out_o with the new accumulator, the 8-bit result, the
// memory write strobe for HL targets and the four flags.
// An accepted instruction enters the execute stage, and its result then moves
// to the output register on out_o, unless an older result still waits there.
// Throughput is one instruction per cycle while out_o is not stalled; the
// register file is read at the accepting edge and written back at retire,
// and a one-entry forwarding register covers that read-after-write window.
// Reset clears the pipeline, the flags and the valid bit of each register
// file entry; an entry that was never written reads as zero.
// When the receiver stalls, the result stays in the output register and one
// more instruction can still enter and wait in the execute stage; after that
// in_i.ready drops until out_o moves again.
`include "eight_bit_cpu_alu_with_flags_defines.svh"

module eight_bit_cpu_alu_with_flags (
  input logic          clk_i,
  input logic          rst_ni,
  ebalu_chan_if.sink   in_i,
  ebalu_chan_if.source out_o
);
  import ebalu_pkg::*;

  in_item_t         in_item;
  logic             in_xfer;

  // Execute stage: the instruction whose register file read is in flight.
  logic             s1_valid_q;
  in_item_t         s1_q;
  logic             s1_vld_sel_q;
  logic             s1_vld_acc_q;
  logic             s1_adv;
  out_item_t        s1_res;

  // Most recent register file write, for forwarding into the execute stage.
  logic             fwd_valid_q;
  logic [SelW-1:0]  fwd_addr_q;
  logic [DataW-1:0] fwd_data_q;

  logic [RegCount-1:0] vld_q;
  flags_t           flags_q;
  flags_t           flags_d;

  logic             out_valid_q;
  out_item_t        out_q;

  logic [DataW-1:0] rd_sel;
  logic [DataW-1:0] rd_acc;
  logic [DataW-1:0] sel_data;
  logic [DataW-1:0] acc;
  logic [DataW-1:0] op;
  logic [DataW-1:0] old;
  logic [DataW-1:0] res;
  logic             cin_eff;
  logic [DataW:0]   add_sum;
  logic [DataW:0]   sub_diff;
  logic [4:0]       add_low;
  logic [4:0]       sub_low;
  logic             is_mem;
  logic             wr_en;
  logic [SelW-1:0]  wr_addr;
  logic [DataW-1:0] wr_data;

  // Terms used by the assertions at the end.
  logic             acc_wr;
  logic             acc_shown;
  logic             mem_target;

  assign in_item = in_i.payload;
  assign in_xfer = in_i.valid & in_i.ready;

  // The execute stage moves on when the output register is empty or drains.
  assign s1_adv     = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | s1_adv;

  // Port A reads the selected register, port B always reads the accumulator.
  ebalu_ram #(
    .Width (DataW),
    .Depth (RegCount)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (s1_adv & wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .re_i      (in_xfer),
    .raddr_a_i (in_item.reg_sel),
    .raddr_b_i (SEL_A),
    .rdata_a_o (rd_sel),
    .rdata_b_o (rd_acc)
  );

  // Operand fetch: the forwarded write wins, then the memory if the entry
  // has ever been written, else the reset value of zero.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_q.reg_sel)) begin
      sel_data = fwd_data_q;
    end else if (s1_vld_sel_q) begin
      sel_data = rd_sel;
    end else begin
      sel_data = '0;
    end
    if (fwd_valid_q && (fwd_addr_q == SEL_A)) begin
      acc = fwd_data_q;
    end else if (s1_vld_acc_q) begin
      acc = rd_acc;
    end else begin
      acc = '0;
    end
  end

  // The memory byte at HL always arrives on operand_value.
  assign is_mem  = (s1_q.reg_sel == SEL_MEM);
  assign op      = (is_mem || s1_q.use_immediate) ? s1_q.operand_value : sel_data;
  assign old     = is_mem ? s1_q.operand_value : sel_data;
  assign cin_eff = flags_q.c & ((s1_q.action == ACT_ADC) || (s1_q.action == ACT_SBC));

  // Shared adder and subtractor; bit 4 of the low-nibble sums is the half carry.
  assign add_sum  = {1'b0, acc} + {1'b0, op} + {{DataW{1'b0}}, cin_eff};
  assign sub_diff = {1'b0, acc} - {1'b0, op} - {{DataW{1'b0}}, cin_eff};
  assign add_low  = {1'b0, acc[3:0]} + {1'b0, op[3:0]} + {4'b0000, cin_eff};
  assign sub_low  = {1'b0, acc[3:0]} - {1'b0, op[3:0]} - {4'b0000, cin_eff};

  always_comb begin
    res     = '0;
    flags_d = flags_q;
    wr_en   = 1'b0;
    wr_addr = SEL_A;
    s1_res.mem_write = 1'b0;
    unique case (s1_q.action) inside
      ACT_LOAD: begin
        res     = s1_q.operand_value;
        wr_addr = s1_q.reg_sel;
        wr_en   = ~is_mem;
        s1_res.mem_write = is_mem;
      end
      ACT_ADD, ACT_ADC: begin
        res     = add_sum[DataW-1:0];
        flags_d = '{z: (add_sum[DataW-1:0] == '0), n: 1'b0, h: add_low[4],
                    c: add_sum[DataW]};
        wr_en   = 1'b1;
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        res     = sub_diff[DataW-1:0];
        flags_d = '{z: (sub_diff[DataW-1:0] == '0), n: 1'b1, h: sub_low[4],
                    c: sub_diff[DataW]};
        wr_en   = (s1_q.action != ACT_CP);
      end
      ACT_AND: begin
        res     = acc & op;
        flags_d = '{z: ((acc & op) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
        wr_en   = 1'b1;
      end
      ACT_XOR: begin
        res     = acc ^ op;
        flags_d = '{z: ((acc ^ op) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wr_en   = 1'b1;
      end
      ACT_OR: begin
        res     = acc | op;
        flags_d = '{z: ((acc | op) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wr_en   = 1'b1;
      end
      ACT_INC: begin
        res     = old + 8'd1;
        flags_d = '{z: (old == 8'hFF), n: 1'b0, h: (old[3:0] == 4'hF), c: flags_q.c};
        wr_addr = s1_q.reg_sel;
        wr_en   = ~is_mem;
        s1_res.mem_write = is_mem;
      end
      ACT_DEC: begin
        res     = old - 8'd1;
        flags_d = '{z: (old == 8'h01), n: 1'b1, h: (old[3:0] == 4'h0), c: flags_q.c};
        wr_addr = s1_q.reg_sel;
        wr_en   = ~is_mem;
        s1_res.mem_write = is_mem;
      end
      ACT_CPL: begin
        res     = ~acc;
        flags_d = '{z: flags_q.z, n: 1'b1, h: 1'b1, c: flags_q.c};
        wr_en   = 1'b1;
      end
      ACT_CCF: begin
        res     = acc;
        flags_d = '{z: flags_q.z, n: 1'b0, h: 1'b0, c: ~flags_q.c};
      end
      default: begin
        // Unused action codes change nothing and report a zero result.
        res = '0;
      end
    endcase

    wr_data                = res;
    s1_res.result_value    = res;
    s1_res.acc_out         = (wr_en && (wr_addr == SEL_A)) ? res : acc;
    s1_res.zero_flag       = flags_d.z;
    s1_res.subtract_flag   = flags_d.n;
    s1_res.half_carry_flag = flags_d.h;
    s1_res.carry_flag      = flags_d.c;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      vld_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        flags_q <= flags_d;
        if (wr_en) begin
          fwd_valid_q    <= 1'b1;
          vld_q[wr_addr] <= 1'b1;
        end
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q         <= in_item;
      s1_vld_sel_q <= vld_q[in_item.reg_sel];
      s1_vld_acc_q <= vld_q[SEL_A];
    end
    if (s1_adv) begin
      out_q <= s1_res;
      if (wr_en) begin
        fwd_addr_q <= wr_addr;
        fwd_data_q <= wr_data;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign acc_wr     = s1_adv & wr_en & (wr_addr == SEL_A);
  assign acc_shown  = out_valid_q & (out_q.acc_out == fwd_data_q);
  assign mem_target = s1_valid_q & s1_res.mem_write;

  // A retired accumulator write shows up as acc_out of that instruction's result.
  `EBALU_ASSERT_NEXT(a_acc_writeback, acc_wr, acc_shown, "accumulator write not in result")
  // The flags only change when an instruction retires.
  `EBALU_ASSERT_NEXT(a_flags_hold, !s1_adv, $stable(flags_q), "flags changed while idle")
  // A memory target never also writes the register file.
  `EBALU_ASSERT_NOW(a_mem_no_regwrite, mem_target, !wr_en, "memory target wrote a register")

endmodule

[bench/ebalu_result_checker.sv]
// Checker that predicts and compares every result of the eight-bit ALU.
`timescale 1ns / 100ps

module ebalu_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ebalu_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ebalu_pkg::out_item_t out_item_i,
  output int unsigned         error_count_o,
  output int unsigned         checked_o,
  output int unsigned         pending_o
);
  import ebalu_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic [DataW-1:0] shadow_regs [RegCount];
  flags_t           shadow_flags;
  out_item_t        expected_results [$];
  int unsigned      mismatch_count;
  int unsigned      checked_count;
  int unsigned      pending_count;

  assign error_count_o = mismatch_count;
  assign checked_o     = checked_count;
  assign pending_o     = pending_count;

  // Executes one instruction on the shadow register file and flags and
  // returns the result the ALU has to report for it.
  function automatic out_item_t execute_instruction(input in_item_t ins);
    logic [DataW-1:0] acc;
    logic [DataW-1:0] operand;
    logic [DataW-1:0] res;
    logic [DataW-1:0] old;
    logic             cin;
    logic             carry_in;
    logic             mw;
    logic [DataW:0]   wide;
    logic [4:0]       nibble;
    out_item_t        item;
    acc      = shadow_regs[SEL_A];
    cin      = shadow_flags.c;
    res      = '0;
    mw       = 1'b0;
    operand  = (ins.reg_sel == SEL_MEM || ins.use_immediate) ? ins.operand_value
                                                             : shadow_regs[ins.reg_sel];
    case (ins.action) inside
      ACT_LOAD: begin
        res = ins.operand_value;
        if (ins.reg_sel == SEL_MEM) begin
          mw = 1'b1;
        end else begin
          shadow_regs[ins.reg_sel] = ins.operand_value;
        end
      end
      ACT_ADD, ACT_ADC: begin
        carry_in = (ins.action == ACT_ADC) ? cin : 1'b0;
        wide     = {1'b0, acc} + {1'b0, operand} + carry_in;
        nibble   = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + carry_in;
        res      = wide[DataW-1:0];
        shadow_flags = '{z: (res == '0), n: 1'b0, h: nibble[4], c: wide[DataW]};
        shadow_regs[SEL_A] = res;
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        carry_in = (ins.action == ACT_SBC) ? cin : 1'b0;
        res      = acc - operand - carry_in;
        shadow_flags = '{z: (res == '0), n: 1'b1,
                         h: ({1'b0, acc[3:0]} < ({1'b0, operand[3:0]} + carry_in)),
                         c: ({1'b0, acc} < ({1'b0, operand} + carry_in))};
        // Compare only sets the flags.
        if (ins.action != ACT_CP) begin
          shadow_regs[SEL_A] = res;
        end
      end
      ACT_AND: begin
        res = acc & operand;
        shadow_flags = '{z: (res == '0), n: 1'b0, h: 1'b1, c: 1'b0};
        shadow_regs[SEL_A] = res;
      end
      ACT_XOR, ACT_OR: begin
        res = (ins.action == ACT_XOR) ? (acc ^ operand) : (acc | operand);
        shadow_flags = '{z: (res == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        shadow_regs[SEL_A] = res;
      end
      ACT_INC, ACT_DEC: begin
        // The immediate flag plays no part here, and carry is kept.
        old = (ins.reg_sel == SEL_MEM) ? ins.operand_value : shadow_regs[ins.reg_sel];
        if (ins.action == ACT_INC) begin
          res = old + 1'b1;
          shadow_flags = '{z: (res == '0), n: 1'b0, h: (old[3:0] == 4'hF), c: cin};
        end else begin
          res = old - 1'b1;
          shadow_flags = '{z: (res == '0), n: 1'b1, h: (old[3:0] == 4'h0), c: cin};
        end
        if (ins.reg_sel == SEL_MEM) begin
          mw = 1'b1;
        end else begin
          shadow_regs[ins.reg_sel] = res;
        end
      end
      ACT_CPL: begin
        res = ~acc;
        shadow_regs[SEL_A] = res;
        shadow_flags.n = 1'b1;
        shadow_flags.h = 1'b1;
      end
      ACT_CCF: begin
        res = acc;
        shadow_flags = '{z: shadow_flags.z, n: 1'b0, h: 1'b0, c: ~cin};
      end
      default: begin
        res = '0;
      end
    endcase
    item.acc_out         = shadow_regs[SEL_A];
    item.result_value    = res;
    item.mem_write       = mw;
    item.zero_flag       = shadow_flags.z;
    item.subtract_flag   = shadow_flags.n;
    item.half_carry_flag = shadow_flags.h;
    item.carry_flag      = shadow_flags.c;
    return item;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        shadow_regs[i] = '0;
      end
      shadow_flags = '0;
      expected_results.delete();
      mismatch_count <= 0;
      checked_count  <= 0;
      pending_count  <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(execute_instruction(in_item_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < ReportLimit) begin
            $display("%0t: result transfer with nothing expected: acc=%h res=%h", $time,
                     out_item_i.acc_out, out_item_i.result_value);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          checked_count <= checked_count + 1;
          if (out_item_i.acc_out !== want.acc_out ||
              out_item_i.result_value !== want.result_value ||
              out_item_i.mem_write !== want.mem_write ||
              out_item_i.zero_flag !== want.zero_flag ||
              out_item_i.subtract_flag !== want.subtract_flag ||
              out_item_i.half_carry_flag !== want.half_carry_flag ||
              out_item_i.carry_flag !== want.carry_flag) begin
            if (mismatch_count < ReportLimit) begin
              $display("%0t: mismatch, expected acc=%h res=%h mw=%b znhc=%b%b%b%b",
                       $time, want.acc_out, want.result_value, want.mem_write,
                       want.zero_flag, want.subtract_flag, want.half_carry_flag,
                       want.carry_flag);
              $display("%0t:             got acc=%h res=%h mw=%b znhc=%b%b%b%b",
                       $time, out_item_i.acc_out, out_item_i.result_value,
                       out_item_i.mem_write, out_item_i.zero_flag,
                       out_item_i.subtract_flag, out_item_i.half_carry_flag,
                       out_item_i.carry_flag);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

[bench/tb_eight_bit_cpu_alu_with_flags.sv]
// Top of the eight-bit ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_eight_bit_cpu_alu_with_flags;
  import ebalu_pkg::*;

  localparam time         HalfPeriod  = 5ns;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned RandomItems = 1625;
  // The result passes the execute stage and the output register; the sink may stall on top.
  localparam int unsigned DrainCycles = 24;
  // Bound on the run length, well above what the slowest correct run needs.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxWait     = 15;

  // Action codes that the block has no operation for.
  localparam logic [ActW-1:0] ACT_UNUSED_LO = 4'd13;
  localparam logic [ActW-1:0] ACT_UNUSED_HI = 4'd15;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        src_burst;
  logic        sink_burst;
  int unsigned sink_wait;
  int unsigned cycles;
  int unsigned sent_count;
  int unsigned directed_count;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned pending_count;

  ebalu_chan_if #(.item_t(in_item_t))  in_ch ();
  ebalu_chan_if #(.item_t(out_item_t)) out_ch ();

  eight_bit_cpu_alu_with_flags DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // The checker only watches both channels; it owns the prediction.
  ebalu_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .in_item_i     (in_ch.payload),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_item_i    (out_ch.payload),
    .error_count_o (error_count),
    .checked_o     (checked_count),
    .pending_o     (pending_count)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // In burst mode a side never idles, otherwise it draws a random wait of up to MaxWait.
  function automatic int unsigned draw_wait(input logic burst);
    return burst ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // Result side. After each transfer the sink draws a stall length and holds
  // ready low for that many cycles. The stall mode flips now and then so that
  // long stretches of back-to-back transfers happen as well.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
      sink_burst   <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = draw_wait(sink_burst);
      out_ch.ready <= (w == 0);
      sink_wait    <= w;
      if ($urandom_range(0, 39) == 0) begin
        sink_burst <= ~sink_burst;
      end
    end else if (sink_wait != 0) begin
      sink_wait    <= sink_wait - 1;
      out_ch.ready <= (sink_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offers one instruction after a random gap and returns at the edge where
  // the transfer takes place. Valid stays high into the next call when that
  // call draws no gap, so it is never dropped and raised in the same step.
  task automatic send_instr(input logic [ActW-1:0] act, input logic [SelW-1:0] sel,
                            input logic imm, input logic [DataW-1:0] val);
    int unsigned gap;
    gap = draw_wait(src_burst);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{action: act, reg_sel: sel, use_immediate: imm, operand_value: val};
    @(posedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
    end
    sent_count++;
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [ActW-1:0]  act;
    logic [SelW-1:0]  sel;
    logic [DataW-1:0] val;
    int unsigned      pick;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    src_burst     = 1'b0;
    sent_count    = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Values are chained so that the steps hit these flag corners:
    // half carry from the low nibble, carry and zero from a full wrap, borrow
    // on subtract, the carry input of ADC and SBC, and the memory operand.
    send_instr(ACT_LOAD, SEL_A,   1'b0, 8'h0F);
    send_instr(ACT_LOAD, SEL_B,   1'b0, 8'h01);
    send_instr(ACT_ADD,  SEL_B,   1'b0, 8'h00);  // 0F + 01: half carry
    send_instr(ACT_LOAD, SEL_C,   1'b0, 8'hFF);
    send_instr(ACT_ADD,  SEL_C,   1'b0, 8'h00);  // 10 + FF: carry out
    send_instr(ACT_ADC,  SEL_B,   1'b1, 8'hF0);  // 0F + F0 + 1: zero, both carries
    // Memory at HL supplies the operand even with the immediate flag clear.
    send_instr(ACT_SUB,  SEL_MEM, 1'b0, 8'h01);  // 00 - 01: borrow
    send_instr(ACT_SBC,  SEL_C,   1'b1, 8'hFE);  // FF - FE - 1: zero
    send_instr(ACT_LOAD, SEL_D,   1'b0, 8'h80);
    send_instr(ACT_LOAD, SEL_E,   1'b0, 8'h7F);
    send_instr(ACT_LOAD, SEL_H,   1'b0, 8'hAA);
    send_instr(ACT_LOAD, SEL_L,   1'b0, 8'h55);
    send_instr(ACT_OR,   SEL_D,   1'b0, 8'h00);
    send_instr(ACT_XOR,  SEL_E,   1'b0, 8'h00);
    send_instr(ACT_AND,  SEL_H,   1'b0, 8'h00);  // AND always sets half carry
    send_instr(ACT_CP,   SEL_A,   1'b1, 8'hAA);  // equal: zero, A kept
    // Memory increment and decrement return write data and keep carry.
    send_instr(ACT_INC,  SEL_MEM, 1'b1, 8'hFF);
    send_instr(ACT_DEC,  SEL_MEM, 1'b0, 8'h00);
    send_instr(ACT_INC,  SEL_E,   1'b0, 8'h00);  // 7F -> 80
    send_instr(ACT_DEC,  SEL_L,   1'b1, 8'hFF);  // immediate flag is ignored
    send_instr(ACT_LOAD, SEL_MEM, 1'b0, 8'h3C);  // load to memory: write strobe only
    send_instr(ACT_CPL,  SEL_B,   1'b1, 8'h5A);
    send_instr(ACT_CCF,  SEL_C,   1'b0, 8'h00);
    send_instr(ACT_CCF,  SEL_D,   1'b1, 8'hFF);
    send_instr(ACT_UNUSED_LO, SEL_A, 1'b1, 8'hFF);
    send_instr(ACT_UNUSED_HI, SEL_MEM, 1'b0, 8'h00);
    directed_count = sent_count;

    // Random part. Loads are weighted up so the register file keeps fresh
    // values, operands lean toward nibble boundaries, and a few unused codes
    // are mixed in as noise.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 50 == 0) begin
        src_burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        act = ActW'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end else if (pick < 18) begin
        act = ACT_LOAD;
      end else begin
        act = ActW'($urandom_range(ACT_LOAD, ACT_CCF));
      end
      sel = SelW'($urandom_range(0, RegCount - 1));
      case ($urandom_range(0, 7))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        2:       val = {4'($urandom_range(0, 15)), 4'hF};
        3:       val = {4'($urandom_range(0, 15)), 4'h0};
        default: val = 8'($urandom);
      endcase
      send_instr(act, sel, 1'($urandom_range(0, 1)), val);
    end
    in_ch.valid <= 1'b0;

    // Let the last acceptance reach the checker before polling its count.
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d instructions (%0d directed, %0d random), %0d results checked.",
             sent_count, directed_count, sent_count - directed_count, checked_count);
    $display("Both sides idled 0 to %0d cycles per transfer, with back-to-back stretches.",
             MaxWait);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/ebalu_pkg.sv
design/ebalu_chan_if.sv
design/ebalu_ram.sv
design/eight_bit_cpu_alu_with_flags.sv
bench/ebalu_result_checker.sv
bench/tb_eight_bit_cpu_alu_with_flags.sv
